// ----- src/butterworth_biquad_cascade_top_defines.svh -----
// assertion macros for the biquad cascade
`ifndef BUTTERWORTH_BIQUAD_CASCADE_TOP_DEFINES_SVH
`define BUTTERWORTH_BIQUAD_CASCADE_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define BBC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define BBC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/bbc_pkg.sv -----
// shared types and constants for the biquad cascade
`default_nettype none

package bbc_pkg;

	localparam int COEF_W  = 16;
	// operand b carries 2*b0 and -a, so two bits over a coefficient
	localparam int OPB_W   = COEF_W + 2;
	localparam int STEP_W  = 3;
	localparam int INDEX_W = 3;

	localparam logic [STEP_W-1:0] LAST_MAC_STEP = 3'd4;
	localparam logic [STEP_W-1:0] WB_STEP       = 3'd6;

	// register indexes
	localparam logic [INDEX_W-1:0] REG_S1_B0 = 3'd0;
	localparam logic [INDEX_W-1:0] REG_S1_A1 = 3'd1;
	localparam logic [INDEX_W-1:0] REG_S1_A2 = 3'd2;
	localparam logic [INDEX_W-1:0] REG_S2_B0 = 3'd3;
	localparam logic [INDEX_W-1:0] REG_S2_A1 = 3'd4;
	localparam logic [INDEX_W-1:0] REG_S2_A2 = 3'd5;

	// quarter-band butterworth defaults
	localparam logic signed [COEF_W-1:0] S1_B0_RST = 16'sd4258;
	localparam logic signed [COEF_W-1:0] S1_A1_RST = 16'sd0;
	localparam logic signed [COEF_W-1:0] S1_A2_RST = 16'sd648;
	localparam logic signed [COEF_W-1:0] S2_B0_RST = 16'sd5925;
	localparam logic signed [COEF_W-1:0] S2_A1_RST = 16'sd0;
	localparam logic signed [COEF_W-1:0] S2_A2_RST = 16'sd7315;

	typedef enum logic [STEP_W-1:0] {
		OP_X  = 3'd0,
		OP_X1 = 3'd1,
		OP_X2 = 3'd2,
		OP_Y1 = 3'd3,
		OP_Y2 = 3'd4
	} op_sel_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic    clr;
		logic    mul_en;
		op_sel_t sel;
		logic    sec;
		logic    wb;
		logic    load_out;
	} ctl_t;

endpackage

`default_nettype wire

// ----- src/bbc_mac.sv -----
// shared multiply-accumulate unit with rounding and saturation
`default_nettype none

module bbc_mac #(
	parameter int SAMPLE_BITS    = 24,
	parameter int COEF_FRAC_BITS = 14
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 clr,
	input  wire logic                                 mul_en,
	input  wire logic signed [SAMPLE_BITS-1:0]        op_a,
	input  wire logic signed [bbc_pkg::OPB_W-1:0]     op_b,
	output logic signed [SAMPLE_BITS-1:0]             y
);

	localparam int PROD_W = SAMPLE_BITS + bbc_pkg::OPB_W;
	// five products, each no larger than 2^(SAMPLE_BITS+15) in magnitude
	localparam int ACC_W  = PROD_W + 1;

	localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
	localparam logic signed [ACC_W-1:0] SMAX = ACC_W'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
	localparam logic signed [ACC_W-1:0] SMIN = ~SMAX;

	logic signed [PROD_W-1:0] prod_s1;
	logic                     valid_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  rnd;
	logic signed [ACC_W-1:0]  shr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= mul_en;
		end
	end

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_s1 <= PROD_W'(op_a) * PROD_W'(op_b);
		end
		if (clr) begin
			acc_q <= '0;
		end else if (valid_s1) begin
			acc_q <= acc_q + ACC_W'(prod_s1);
		end
	end

	// round half up, then clamp to the sample range
	always_comb begin
		rnd = acc_q + HALF;
		shr = rnd >>> COEF_FRAC_BITS;
		if (shr > SMAX) begin
			y = SMAX[SAMPLE_BITS-1:0];
		end else if (shr < SMIN) begin
			y = SMIN[SAMPLE_BITS-1:0];
		end else begin
			y = shr[SAMPLE_BITS-1:0];
		end
	end

endmodule

`default_nettype wire

// ----- src/bbc_ctrl.sv -----
// sequencer stepping the shared mac through both sections
`default_nettype none

module bbc_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire logic           out_free,
	output logic                busy,
	output bbc_pkg::ctl_t       ctl
);

	bbc_pkg::state_t                    state_q, state_d;
	logic [bbc_pkg::STEP_W-1:0]         step_q, step_d;
	logic                               sec_q, sec_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bbc_pkg::ST_IDLE;
			step_q  <= '0;
			sec_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			sec_q   <= sec_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		step_d       = step_q;
		sec_d        = sec_q;
		ctl.clr      = 1'b0;
		ctl.mul_en   = 1'b0;
		ctl.sel      = bbc_pkg::OP_X;
		ctl.sec      = sec_q;
		ctl.wb       = 1'b0;
		ctl.load_out = 1'b0;
		busy         = (state_q != bbc_pkg::ST_IDLE);
		case (state_q)
			bbc_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = bbc_pkg::ST_RUN;
					step_d  = '0;
					sec_d   = 1'b0;
				end
			end
			bbc_pkg::ST_RUN: begin
				if (step_q == bbc_pkg::WB_STEP) begin
					// section result is final, update its delays
					ctl.wb = 1'b1;
					step_d = '0;
					if (sec_q) begin
						state_d = bbc_pkg::ST_DONE;
					end else begin
						sec_d = 1'b1;
					end
				end else begin
					ctl.clr = (step_q == '0);
					if (step_q <= bbc_pkg::LAST_MAC_STEP) begin
						ctl.mul_en = 1'b1;
						ctl.sel    = bbc_pkg::op_sel_t'(step_q);
					end
					step_d = step_q + bbc_pkg::STEP_W'(1);
				end
			end
			bbc_pkg::ST_DONE: begin
				if (out_free) begin
					ctl.load_out = 1'b1;
					state_d      = bbc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bbc_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- src/butterworth_biquad_cascade_top.sv -----
// fourth-order butterworth low-pass, two direct-form-i biquads on one mac
`default_nettype none

// Fourth-order low-pass filter built as two direct-form-I biquad sections in
// series, y = b0*x + 2*b0*x1 + b0*x2 - a1*y1 - a2*y2, each section rounded
// half up to the sample grid and saturated. One signed multiplier with an
// accumulator does all ten products in turn: per section five products, a
// drain of the product register, then rounding, saturation and a delay
// update; after both sections the word goes to the output register. A new
// word is taken only once the block is idle again, and the output register
// lets it in while a result still waits. Coefficients are signed with
// COEF_FRAC_BITS fraction bits and reset to the quarter-band design. The user
// must write them through cfg_wr/cfg_index/cfg_data only while the block is
// idle; the block does not enforce this. Writes to indexes past 5 are dropped.

module butterworth_biquad_cascade_top #(
	parameter int SAMPLE_BITS    = 24,
	parameter int COEF_FRAC_BITS = 14
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic signed [SAMPLE_BITS-1:0]       sample_in,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic signed [SAMPLE_BITS-1:0]            sample_out,
	input  wire logic                                cfg_wr,
	input  wire logic [bbc_pkg::INDEX_W-1:0]         cfg_index,
	input  wire logic [bbc_pkg::COEF_W-1:0]          cfg_data
);

`include "butterworth_biquad_cascade_top_defines.svh"

	localparam int OPB_W = bbc_pkg::OPB_W;

	logic signed [bbc_pkg::COEF_W-1:0] b0_q [2];
	logic signed [bbc_pkg::COEF_W-1:0] a1_q [2];
	logic signed [bbc_pkg::COEF_W-1:0] a2_q [2];

	logic signed [SAMPLE_BITS-1:0] x1_q [2];
	logic signed [SAMPLE_BITS-1:0] x2_q [2];
	logic signed [SAMPLE_BITS-1:0] y1_q [2];
	logic signed [SAMPLE_BITS-1:0] y2_q [2];

	logic signed [SAMPLE_BITS-1:0] x_q;
	logic signed [SAMPLE_BITS-1:0] mid_q;
	logic signed [SAMPLE_BITS-1:0] x_cur;
	logic signed [SAMPLE_BITS-1:0] y_new;
	logic signed [SAMPLE_BITS-1:0] op_a;
	logic signed [OPB_W-1:0]       op_b;
	logic signed [OPB_W-1:0]       b0_ext;

	logic          out_valid_q;
	logic          out_free;
	logic          busy;
	logic          in_accept;
	bbc_pkg::ctl_t ctl;

	assign in_stall  = busy;
	assign in_accept = in_valid && !busy;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	bbc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_free (out_free),
		.busy     (busy),
		.ctl      (ctl)
	);

	bbc_mac #(
		.SAMPLE_BITS    (SAMPLE_BITS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (ctl.clr),
		.mul_en (ctl.mul_en),
		.op_a   (op_a),
		.op_b   (op_b),
		.y      (y_new)
	);

	// second section runs on the first section's output
	assign x_cur  = ctl.sec ? mid_q : x_q;
	assign b0_ext = OPB_W'(b0_q[ctl.sec]);

	always_comb begin
		case (ctl.sel)
			bbc_pkg::OP_X: begin
				op_a = x_cur;
				op_b = b0_ext;
			end
			bbc_pkg::OP_X1: begin
				op_a = x1_q[ctl.sec];
				op_b = b0_ext <<< 1;
			end
			bbc_pkg::OP_X2: begin
				op_a = x2_q[ctl.sec];
				op_b = b0_ext;
			end
			bbc_pkg::OP_Y1: begin
				op_a = y1_q[ctl.sec];
				op_b = -OPB_W'(a1_q[ctl.sec]);
			end
			bbc_pkg::OP_Y2: begin
				op_a = y2_q[ctl.sec];
				op_b = -OPB_W'(a2_q[ctl.sec]);
			end
			default: begin
				op_a = x_cur;
				op_b = b0_ext;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_q[0] <= bbc_pkg::S1_B0_RST;
			a1_q[0] <= bbc_pkg::S1_A1_RST;
			a2_q[0] <= bbc_pkg::S1_A2_RST;
			b0_q[1] <= bbc_pkg::S2_B0_RST;
			a1_q[1] <= bbc_pkg::S2_A1_RST;
			a2_q[1] <= bbc_pkg::S2_A2_RST;
		end else if (cfg_wr) begin
			case (cfg_index)
				bbc_pkg::REG_S1_B0: b0_q[0] <= cfg_data;
				bbc_pkg::REG_S1_A1: a1_q[0] <= cfg_data;
				bbc_pkg::REG_S1_A2: a2_q[0] <= cfg_data;
				bbc_pkg::REG_S2_B0: b0_q[1] <= cfg_data;
				bbc_pkg::REG_S2_A1: a1_q[1] <= cfg_data;
				bbc_pkg::REG_S2_A2: a2_q[1] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q[0] <= '0;
			x1_q[1] <= '0;
			x2_q[0] <= '0;
			x2_q[1] <= '0;
			y1_q[0] <= '0;
			y1_q[1] <= '0;
			y2_q[0] <= '0;
			y2_q[1] <= '0;
		end else if (ctl.wb) begin
			x2_q[ctl.sec] <= x1_q[ctl.sec];
			x1_q[ctl.sec] <= x_cur;
			y2_q[ctl.sec] <= y1_q[ctl.sec];
			y1_q[ctl.sec] <= y_new;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			x_q <= sample_in;
		end
		if (ctl.wb && !ctl.sec) begin
			mid_q <= y_new;
		end
		if (ctl.load_out) begin
			sample_out <= y1_q[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	`BBC_ASSERT_NEXT(a_accept_busy, in_accept, in_stall, "word accepted but block not busy")
	`BBC_ASSERT_NOW(a_load_free, ctl.load_out, out_free, "result overwrites a waiting word")
	`BBC_ASSERT_NOW(a_mac_busy, ctl.mul_en || ctl.wb, busy, "mac step while idle")

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// testbench for the biquad cascade: random and directed samples checked against a predictor
`timescale 1ns / 1ps

module tb_top;

	localparam int SAMPLE_W   = 24;
	localparam int FRAC_W     = 14;
	localparam longint SAT_HI = (longint'(1) << (SAMPLE_W - 1)) - 1;
	localparam longint SAT_LO = -(longint'(1) << (SAMPLE_W - 1));
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 24'h7FFFFF;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 24'h800000;
	localparam logic [bbc_pkg::INDEX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [bbc_pkg::INDEX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 300;
	localparam int DRAIN_CYCLES   = 40;

	typedef struct packed {
		logic [bbc_pkg::COEF_W-1:0] s1_b0;
		logic [bbc_pkg::COEF_W-1:0] s1_a1;
		logic [bbc_pkg::COEF_W-1:0] s1_a2;
		logic [bbc_pkg::COEF_W-1:0] s2_b0;
		logic [bbc_pkg::COEF_W-1:0] s2_a1;
		logic [bbc_pkg::COEF_W-1:0] s2_a2;
	} coef_set_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic [SAMPLE_W-1:0] sample_in = '0;
	logic out_stall = 1'b0;
	logic cfg_wr = 1'b0;
	logic [bbc_pkg::INDEX_W-1:0] cfg_index = '0;
	logic [bbc_pkg::COEF_W-1:0] cfg_data = '0;
	logic in_stall;
	logic out_valid;
	logic [SAMPLE_W-1:0] sample_out;

	// predictor state
	coef_set_t active_coefs;
	logic [SAMPLE_W-1:0] x_dly [4];
	logic [SAMPLE_W-1:0] y_dly [4];

	logic [SAMPLE_W-1:0] pending_samples [$];
	logic [SAMPLE_W-1:0] due_outputs [$];

	bit in_fire = 1'b0;
	int items_in = 0;
	int mismatches = 0;
	int tx_idle_pct = 14;
	int rx_stall_pct = 49;
	int hold_at = -1;
	int hold_done_at = -1;
	int hold_left = 0;

	butterworth_biquad_cascade_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample_in (sample_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sample_out(sample_out),
		.cfg_wr    (cfg_wr),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// one direct-form-i section; rounds half up, saturates, shifts its delays
	function automatic logic [SAMPLE_W-1:0] run_biquad(input int sec,
			input logic [bbc_pkg::COEF_W-1:0] b0_u,
			input logic [bbc_pkg::COEF_W-1:0] a1_u, input logic [bbc_pkg::COEF_W-1:0] a2_u,
			input logic [SAMPLE_W-1:0] x_u);
		longint b0, a1, a2, acc, q;
		logic [SAMPLE_W-1:0] y;
		b0 = longint'($signed(b0_u));
		a1 = longint'($signed(a1_u));
		a2 = longint'($signed(a2_u));
		acc = b0 * longint'($signed(x_u))
			+ 2 * b0 * longint'($signed(x_dly[2*sec]))
			+ b0 * longint'($signed(x_dly[2*sec+1]))
			- a1 * longint'($signed(y_dly[2*sec]))
			- a2 * longint'($signed(y_dly[2*sec+1]));
		q = (acc + (longint'(1) << (FRAC_W - 1))) >>> FRAC_W;
		if (q > SAT_HI)
			y = SAMPLE_MAX;
		else if (q < SAT_LO)
			y = SAMPLE_MIN;
		else
			y = q[SAMPLE_W-1:0];
		x_dly[2*sec+1] = x_dly[2*sec];
		x_dly[2*sec] = x_u;
		y_dly[2*sec+1] = y_dly[2*sec];
		y_dly[2*sec] = y;
		return y;
	endfunction

	function automatic logic [SAMPLE_W-1:0] filter_sample(input logic [SAMPLE_W-1:0] x);
		logic [SAMPLE_W-1:0] mid;
		mid = run_biquad(0, active_coefs.s1_b0, active_coefs.s1_a1, active_coefs.s1_a2, x);
		return run_biquad(1, active_coefs.s2_b0, active_coefs.s2_a1, active_coefs.s2_a2, mid);
	endfunction

	function automatic coef_set_t uniform_set(input logic [bbc_pkg::COEF_W-1:0] b0,
			input logic [bbc_pkg::COEF_W-1:0] a1, input logic [bbc_pkg::COEF_W-1:0] a2);
		return '{b0, a1, a2, b0, a1, a2};
	endfunction

	// b0, a1, a2 of one section inside the stability triangle
	function automatic logic [3*bbc_pkg::COEF_W-1:0] stable_section();
		int b0, a1, a2;
		logic [bbc_pkg::COEF_W-1:0] b0_v, a1_v, a2_v;
		a2 = int'($urandom_range(30000)) - 15000;
		a1 = $urandom_range(16000 + a2);
		if ($urandom_range(1))
			a1 = -a1;
		b0 = int'($urandom_range(6000)) - 3000;
		b0_v = b0[bbc_pkg::COEF_W-1:0];
		a1_v = a1[bbc_pkg::COEF_W-1:0];
		a2_v = a2[bbc_pkg::COEF_W-1:0];
		return {b0_v, a1_v, a2_v};
	endfunction

	function automatic logic [SAMPLE_W-1:0] random_sample(input logic [SAMPLE_W-1:0] prev);
		int kind, small_v;
		kind = $urandom_range(9);
		small_v = int'($urandom_range(1023)) - 512;
		case (kind)
			0, 1, 2, 3: return SAMPLE_W'($urandom);
			4, 5:       return small_v[SAMPLE_W-1:0];
			6:          return SAMPLE_MAX;
			7:          return SAMPLE_MIN;
			default:    return prev;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [SAMPLE_W-1:0] got,
			input logic [SAMPLE_W-1:0] want);
		$display("mismatch at %0t: %s, got %0d want %0d", $realtime, what,
			$signed(got), $signed(want));
		mismatches++;
	endtask

	task automatic write_reg(input logic [bbc_pkg::INDEX_W-1:0] idx,
			input logic [bbc_pkg::COEF_W-1:0] val);
		@(negedge clk);
		cfg_wr <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			bbc_pkg::REG_S1_B0: active_coefs.s1_b0 = val;
			bbc_pkg::REG_S1_A1: active_coefs.s1_a1 = val;
			bbc_pkg::REG_S1_A2: active_coefs.s1_a2 = val;
			bbc_pkg::REG_S2_B0: active_coefs.s2_b0 = val;
			bbc_pkg::REG_S2_A1: active_coefs.s2_a1 = val;
			bbc_pkg::REG_S2_A2: active_coefs.s2_a2 = val;
			default: ;
		endcase
	endtask

	// also hits the two unused indexes, which must change nothing
	task automatic load_coefs(input coef_set_t c);
		write_reg(bbc_pkg::REG_S1_B0, c.s1_b0);
		write_reg(REG_SPARE_LO, bbc_pkg::COEF_W'($urandom));
		write_reg(bbc_pkg::REG_S1_A1, c.s1_a1);
		write_reg(bbc_pkg::REG_S1_A2, c.s1_a2);
		write_reg(bbc_pkg::REG_S2_B0, c.s2_b0);
		write_reg(bbc_pkg::REG_S2_A1, c.s2_a1);
		write_reg(REG_SPARE_HI, bbc_pkg::COEF_W'($urandom));
		write_reg(bbc_pkg::REG_S2_A2, c.s2_a2);
		@(negedge clk);
		cfg_wr <= 1'b0;
	endtask

	task automatic queue_random(input int n);
		logic [SAMPLE_W-1:0] s;
		s = '0;
		repeat (n) begin
			s = random_sample(s);
			pending_samples.push_back(s);
		end
	endtask

	// checked just after the falling edge so the sender's update is settled
	task automatic wait_drained();
		@(negedge clk);
		#1;
		while (pending_samples.size() != 0 || in_valid || due_outputs.size() != 0) begin
			@(negedge clk);
			#1;
		end
	endtask

	// sender: a new word only once the current one has been taken
	always @(negedge clk) begin
		if (!in_valid || in_fire) begin
			if (arst_n && pending_samples.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				in_valid <= 1'b1;
				sample_in <= pending_samples.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls plus one long hold-off when asked
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (hold_at >= 0 && items_in >= hold_at && hold_done_at != hold_at) begin
			out_stall <= 1'b1;
			hold_left = HOLD_CYCLES;
			hold_done_at = hold_at;
		end else begin
			out_stall <= ($urandom_range(99) < rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		logic [SAMPLE_W-1:0] want;
		in_fire = arst_n && in_valid && !in_stall;
		if (in_fire) begin
			due_outputs.push_back(filter_sample(sample_in));
			items_in++;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (due_outputs.size() == 0) begin
				report_mismatch("word with nothing expected", sample_out, '0);
			end else begin
				want = due_outputs.pop_front();
				if (sample_out !== want)
					report_mismatch("sample_out", sample_out, want);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr || !arst_n)
				quiet = 0;
			else
				quiet++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		active_coefs = '{bbc_pkg::S1_B0_RST, bbc_pkg::S1_A1_RST, bbc_pkg::S1_A2_RST,
			bbc_pkg::S2_B0_RST, bbc_pkg::S2_A1_RST, bbc_pkg::S2_A2_RST};
		for (int i = 0; i < 4; i++) begin
			x_dly[i] = '0;
			y_dly[i] = '0;
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset coefficients: impulse, steps at both rails, nyquist, bit patterns
		pending_samples = '{24'd0, 24'd1, 24'hFFFFFF, SAMPLE_MAX, 24'd0, 24'd0, SAMPLE_MIN,
			SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN,
			SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN,
			24'h555555, 24'hAAAAAA, 24'd0};
		queue_random(40);
		wait_drained();

		// all coefficients at the top rail, then the bottom rail
		load_coefs(uniform_set(16'h7FFF, 16'h7FFF, 16'h7FFF));
		pending_samples = '{SAMPLE_MAX, SAMPLE_MIN, 24'd0, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN};
		queue_random(40);
		wait_drained();
		load_coefs(uniform_set(16'h8000, 16'h8000, 16'h8000));
		pending_samples = '{SAMPLE_MIN, SAMPLE_MAX, 24'd0, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX};
		queue_random(40);
		wait_drained();

		tx_idle_pct = 49;
		rx_stall_pct = 14;
		load_coefs(coef_set_t'({stable_section(), stable_section()}));
		queue_random(80);
		wait_drained();
		load_coefs(uniform_set(16'h0000, 16'h0000, 16'h0000));
		queue_random(20);
		wait_drained();
		load_coefs(coef_set_t'({$urandom, $urandom, $urandom}));
		queue_random(40);
		wait_drained();

		// no idling; the long hold-off backs the block up into its input
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		load_coefs('{bbc_pkg::S1_B0_RST, bbc_pkg::S1_A1_RST, bbc_pkg::S1_A2_RST,
			bbc_pkg::S2_B0_RST, bbc_pkg::S2_A1_RST, bbc_pkg::S2_A2_RST});
		hold_at = items_in + 20;
		queue_random(120);
		wait_drained();
		load_coefs(coef_set_t'({stable_section(), stable_section()}));
		queue_random(80);
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && due_outputs.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
